@@ design/bbe_pkg.sv @@
`default_nettype none
package bbe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int PIX_W    = 32;
  localparam int SUM_W    = 12;
  localparam int CNT_W    = 4;
  localparam int RCP_W    = 17;
  localparam int RCP_SH   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // one pixel slot handed from front to back
  typedef struct packed {
    logic [AW-1:0]    addr;
    logic [PIX_W-1:0] pix;
    logic             emit;
    logic             ok_l;
    logic             ok_r;
    logic             ok_t;
    logic             ok_b;
    logic             last;
  } bbe_cmd_t;

  typedef struct packed {
    logic     push;
    bbe_cmd_t cmd;
  } bbe_push_t;

  // ceil(2^16 / d); exact truncating division for sums below 2^16 / d
  function automatic logic [RCP_W-1:0] bbe_recip(input logic [CNT_W-1:0] d);
    logic [RCP_W-1:0] r;
    begin
      case (d)
        4'd1:    r = 17'd65536;
        4'd2:    r = 17'd32768;
        4'd3:    r = 17'd21846;
        4'd4:    r = 17'd16384;
        4'd5:    r = 17'd13108;
        4'd6:    r = 17'd10923;
        4'd7:    r = 17'd9363;
        4'd8:    r = 17'd8192;
        4'd9:    r = 17'd7282;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ design/bbe_front.sv @@
`default_nettype none
module bbe_front import bbe_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic [PIX_W-1:0]     in_pix_i,
  input  wire logic                 in_pad_i,
  input  wire logic                 q_full_i,
  output bbe_push_t                 push_o
);

  logic [WIDTH_W-1:0]  fw_q;
  logic [HEIGHT_W-1:0] fh_q;
  logic [AW-1:0]       col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;
  logic [WIDTH_W-1:0]  w;
  logic [HEIGHT_W-1:0] h;
  logic                in_frame, take, emit, last;
  logic [AW-1:0]       x;
  logic [HEIGHT_W-1:0] y;
  logic [WIDTH_W-1:0]  col_p1;

  always_comb begin
    if (fw_q == '0) w = WIDTH_W'(1);
    else if (fw_q > WIDTH_W'(MAX_WIDTH)) w = WIDTH_W'(MAX_WIDTH);
    else w = fw_q;
    if (fh_q == '0) h = HEIGHT_W'(1);
    else if (fh_q > HEIGHT_W'(MAX_HEIGHT)) h = HEIGHT_W'(MAX_HEIGHT);
    else h = fh_q;
  end

  assign in_frame = row_q < h;
  assign take     = in_valid_i && !q_full_i && !(in_pad_i && in_frame);
  assign emit     = (row_q >= HEIGHT_W'(2)) || (row_q == HEIGHT_W'(1) && col_q != '0);
  assign x        = (col_q != '0) ? col_q - AW'(1) : AW'(w - WIDTH_W'(1));
  assign y        = (col_q != '0) ? row_q - HEIGHT_W'(1) : row_q - HEIGHT_W'(2);
  assign last     = emit && ({1'b0, x} == w - WIDTH_W'(1)) && (y == h - HEIGHT_W'(1));
  assign col_p1   = WIDTH_W'(col_q) + WIDTH_W'(1);

  always_comb begin
    push_o.push     = take;
    push_o.cmd.addr = col_q;
    push_o.cmd.pix  = (in_frame && !in_pad_i) ? in_pix_i : '0;
    push_o.cmd.emit = emit;
    push_o.cmd.ok_l = x != '0;
    push_o.cmd.ok_r = ({1'b0, x} + WIDTH_W'(1)) < w;
    push_o.cmd.ok_t = y != '0;
    push_o.cmd.ok_b = (y + HEIGHT_W'(1)) < h;
    push_o.cmd.last = last;
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_p1 >= w) begin
        col_d = '0;
        row_d = row_q + HEIGHT_W'(1);
      end else begin
        col_d = AW'(col_p1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= WIDTH_W'(640);
      fh_q  <= HEIGHT_W'(480);
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_valid_i) begin
      // a write to the frame width or height register restarts the frame
      if (cfg_index_i == REG_FRAME_WIDTH) begin
        fw_q  <= cfg_data_i[WIDTH_W-1:0];
        col_q <= '0;
        row_q <= '0;
      end else if (cfg_index_i == REG_FRAME_HEIGHT) begin
        fh_q  <= cfg_data_i;
        col_q <= '0;
        row_q <= '0;
      end
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule
`default_nettype wire

@@ design/bbe_fifo.sv @@
`default_nettype none
module bbe_fifo import bbe_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  bbe_push_t  push_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       empty_o,
  output bbe_cmd_t   head_o
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  bbe_cmd_t        mem_q [DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;

  assign full_o  = cnt_q == (PW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push) mem_q[wp_q] <= push_i.cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.push) wp_q <= wp_q + PW'(1);
      if (pop_i) rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i.push) - (PW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

@@ design/bbe_back.sv @@
`default_nettype none
module bbe_back import bbe_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  empty_i,
  input  bbe_cmd_t   head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  output logic       frame_end_o
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic             adv;
  logic             s1_vld_q;
  bbe_cmd_t         s1_q;
  logic [PIX_W-1:0] top_rd_q, mid_rd_q, byp_top_q, byp_mid_q;
  logic             byp_q;
  logic [PIX_W-1:0] top, mid;
  logic [PIX_W-1:0] win_q [6];

  logic             s2_vld_q;
  logic [SUM_W-1:0] sum_q [4];
  logic [RCP_W-1:0] rcp_q;
  logic             last_q;

  logic [SUM_W-1:0] sum_d [4];
  logic [CNT_W-1:0] cnt;
  logic [1:0]       ncol, nrow;
  logic [PIX_W-1:0] px [9];
  logic             okp [9];

  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && !empty_i;
  assign top   = byp_q ? byp_top_q : top_rd_q;
  assign mid   = byp_q ? byp_mid_q : mid_rd_q;

  // window order: column-major left, centre, right; rows top, mid, bottom
  always_comb begin
    px[0] = win_q[0]; px[1] = win_q[1]; px[2] = win_q[2];
    px[3] = win_q[3]; px[4] = win_q[4]; px[5] = win_q[5];
    px[6] = top;      px[7] = mid;      px[8] = s1_q.pix;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        okp[3*i+j] = (i == 1 || (i == 0 ? s1_q.ok_l : s1_q.ok_r)) &&
                     (j == 1 || (j == 0 ? s1_q.ok_t : s1_q.ok_b));
      end
    end
    for (int k = 0; k < 4; k++) begin
      sum_d[k] = '0;
      for (int n = 0; n < 9; n++) begin
        if (okp[n]) sum_d[k] = sum_d[k] + SUM_W'(px[n][8*k +: 8]);
      end
    end
    ncol = 2'd1 + 2'(s1_q.ok_l) + 2'(s1_q.ok_r);
    nrow = 2'd1 + 2'(s1_q.ok_t) + 2'(s1_q.ok_b);
    cnt  = CNT_W'(ncol) * CNT_W'(nrow);
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      upper_mem[s1_q.addr]  <= mid;
      middle_mem[s1_q.addr] <= s1_q.pix;
    end
    if (pop_o) begin
      top_rd_q  <= upper_mem[head_i.addr];
      mid_rd_q  <= middle_mem[head_i.addr];
      byp_top_q <= mid;
      byp_mid_q <= s1_q.pix;
      s1_q      <= head_i;
    end
    if (adv && s1_vld_q) begin
      for (int k = 0; k < 4; k++) sum_q[k] <= sum_d[k];
      rcp_q  <= bbe_recip(cnt);
      last_q <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      byp_q       <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (adv) begin
      s1_vld_q <= pop_o;
      // same address read while the previous slot writes it (one-pixel rows)
      byp_q    <= pop_o && s1_vld_q && (s1_q.addr == head_i.addr);
      s2_vld_q <= s1_vld_q && s1_q.emit;
      out_valid_o <= s2_vld_q;
      if (s1_vld_q) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= s1_q.pix;
      end
    end
  end

  logic [SUM_W+RCP_W-1:0] prod [4];
  always_comb begin
    for (int k = 0; k < 4; k++) prod[k] = (SUM_W+RCP_W)'(sum_q[k]) * (SUM_W+RCP_W)'(rcp_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_q) begin
      out_red_o   <= prod[0][RCP_SH +: 8];
      out_green_o <= prod[1][RCP_SH +: 8];
      out_blue_o  <= prod[2][RCP_SH +: 8];
      out_alpha_o <= prod[3][RCP_SH +: 8];
      frame_end_o <= last_q;
    end
  end

endmodule
`default_nettype wire

@@ design/box_blur_3x3_edge_normalized_unit.sv @@
`default_nettype none
// channel  dir  handshake            payload
// cfg      in   cfg_valid/cfg_ready  cfg_index_i, cfg_data_i
// in       in   in_valid/in_stall    in_red/green/blue/alpha_i, is_padding_i
// out      out  out_valid/out_stall  out_red/green/blue/alpha_o, frame_end_o
//
// One pixel per cycle sustained while the output is not stalled; each accepted pixel passes
// the queue, then the row-store read, window sum and reciprocal multiply (result) registers.
// The row stores are memories with one read and one write port, each used once per pixel.
// Reset clears counters, window and pipeline valids; row stores stay unset.
// A stalled output freezes the back pipeline; the 4-entry queue then fills and
// stalls the input.
module box_blur_3x3_edge_normalized_unit import bbe_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           in_red_i,
  input  wire logic [7:0]           in_green_i,
  input  wire logic [7:0]           in_blue_i,
  input  wire logic [7:0]           in_alpha_i,
  input  wire logic                 is_padding_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                out_red_o,
  output logic [7:0]                out_green_o,
  output logic [7:0]                out_blue_o,
  output logic [7:0]                out_alpha_o,
  output logic                      frame_end_o
);

  bbe_push_t push;
  bbe_cmd_t  head;
  logic      q_full, q_empty, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  bbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_pix_i    ({in_alpha_i, in_blue_i, in_green_i, in_red_i}),
    .in_pad_i    (is_padding_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  bbe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  bbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o),
    .frame_end_o (frame_end_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push |-> !q_full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("queue pop while empty");

  a_stall_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !pop) else $error("pop while output stalled");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import bbe_pkg::*;

  localparam int CycleLimit = 2_000_000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       pad;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
  } blur_pixel_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [7:0] in_red_i, in_green_i, in_blue_i, in_alpha_i;
  logic is_padding_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic frame_end_o;

  box_blur_3x3_edge_normalized_unit i_dut (.*);

  // predictor state
  logic [31:0] upper_row[MAX_WIDTH];
  logic [31:0] middle_row[MAX_WIDTH];
  logic [31:0] window[6];
  int unsigned col_pos, row_pos;
  int unsigned width_reg, height_reg;

  pixel_item_t pixel_queue[$];
  blur_pixel_t blurred_queue[$];
  int unsigned n_errors, n_pixels_in, n_blurred, n_frame_ends, n_cycles;
  logic in_took;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic blur_step(input pixel_item_t it);
    int unsigned w, h, c, r, x, y, cnt;
    logic [31:0] pix, top, mid;
    logic [31:0] grid[9];
    bit ok_col[3], ok_row[3];
    int unsigned sum[4];
    blur_pixel_t res;
    begin
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      if (it.pad && row_pos < h) return;
      pix = (!it.pad && row_pos < h) ? {it.alpha, it.blue, it.green, it.red} : '0;
      if (col_pos >= w) col_pos = 0;
      c = col_pos;
      r = row_pos;
      top = upper_row[c];
      mid = middle_row[c];
      upper_row[c] = mid;
      middle_row[c] = pix;
      // grid index: column * 3 + row
      for (int i = 0; i < 6; i++) grid[i] = window[i];
      grid[6] = top;
      grid[7] = mid;
      grid[8] = pix;
      if (r >= 2 || (r == 1 && c >= 1)) begin
        x = (c >= 1) ? c - 1 : w - 1;
        y = (c >= 1) ? r - 1 : r - 2;
        ok_col[0] = x >= 1; ok_col[1] = 1; ok_col[2] = x + 1 < w;
        ok_row[0] = y >= 1; ok_row[1] = 1; ok_row[2] = y + 1 < h;
        sum = '{0, 0, 0, 0};
        cnt = 0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            if (ok_col[i] && ok_row[j]) begin
              for (int k = 0; k < 4; k++) sum[k] += grid[i*3+j][8*k +: 8];
              cnt++;
            end
          end
        end
        res.red = 8'(sum[0] / cnt);
        res.green = 8'(sum[1] / cnt);
        res.blue = 8'(sum[2] / cnt);
        res.alpha = 8'(sum[3] / cnt);
        res.frame_end = (x == w - 1) && (y == h - 1);
        blurred_queue.push_back(res);
        if (res.frame_end) begin
          for (int i = 0; i < 6; i++) window[i] = grid[i+3];
          col_pos = 0;
          row_pos = 0;
          return;
        end
      end
      for (int i = 0; i < 6; i++) window[i] = grid[i+3];
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
    end
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_item_t rand_pixel(bit pad);
    pixel_item_t it;
    it.red = rand_byte();
    it.green = rand_byte();
    it.blue = rand_byte();
    it.alpha = rand_byte();
    it.pad = pad;
    return it;
  endfunction

  // idle percentages rotate through three phases as pixels are transferred
  function automatic int unsigned sender_idle();
    case ((n_pixels_in / 330) % 3)
      0: return 34;
      1: return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle();
    case ((n_pixels_in / 330) % 3)
      0: return 51;
      1: return 34;
      default: return 0;
    endcase
  endfunction

  // input channel driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle()) begin
        pixel_item_t it;
        it = pixel_queue.pop_front();
        {in_red_i, in_green_i, in_blue_i, in_alpha_i, is_padding_i} <= it;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_idle());
  end

  always @(posedge clk_i) begin
    in_took <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      blur_step({in_red_i, in_green_i, in_blue_i, in_alpha_i, is_padding_i});
      n_pixels_in++;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      blur_pixel_t exp_px;
      if (blurred_queue.size() == 0) begin
        $error("unexpected output transfer");
        n_errors++;
      end else begin
        exp_px = blurred_queue.pop_front();
        n_blurred++;
        if (exp_px.frame_end) n_frame_ends++;
        if (out_red_o !== exp_px.red) begin
          $error("out_red: expected %0d, got %0d", exp_px.red, out_red_o);
          n_errors++;
        end
        if (out_green_o !== exp_px.green) begin
          $error("out_green: expected %0d, got %0d", exp_px.green, out_green_o);
          n_errors++;
        end
        if (out_blue_o !== exp_px.blue) begin
          $error("out_blue: expected %0d, got %0d", exp_px.blue, out_blue_o);
          n_errors++;
        end
        if (out_alpha_o !== exp_px.alpha) begin
          $error("out_alpha: expected %0d, got %0d", exp_px.alpha, out_alpha_o);
          n_errors++;
        end
        if (frame_end_o !== exp_px.frame_end) begin
          $error("frame_end: expected %0d, got %0d", exp_px.frame_end, frame_end_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_drained();
    wait (pixel_queue.size() == 0 && !in_valid_i && blurred_queue.size() == 0);
    // a trailing drain or ignored item may still be in flight
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_FRAME_WIDTH) width_reg = data[WIDTH_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) height_reg = data[HEIGHT_W-1:0];
    col_pos = 0;
    row_pos = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // queues one frame and its drain; stray padding and a cut-short end are optional
  task automatic queue_frame(input bit noisy, input bit cut_short);
    int unsigned w, h, stop_at;
    begin
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      stop_at = cut_short ? $urandom_range(w * h) : w * h + w + 1;
      for (int unsigned i = 0; i < w * h + w + 1 && i < stop_at; i++) begin
        if (noisy && i < w * h && $urandom_range(9) == 0)
          pixel_queue.push_back(rand_pixel(1'b1));
        if (i < w * h) pixel_queue.push_back(rand_pixel(1'b0));
        else pixel_queue.push_back(rand_pixel(1'($urandom_range(1))));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    {in_red_i, in_green_i, in_blue_i, in_alpha_i, is_padding_i} = '0;
    out_stall_i = 1'b0;
    in_took = 1'b0;
    n_errors = 0;
    n_pixels_in = 0;
    n_blurred = 0;
    n_frame_ends = 0;
    n_cycles = 0;
    width_reg = 640;
    height_reg = 480;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 6; i++) window[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, zero sizes clamped to one
    set_frame(13'd1, 13'd1);
    queue_frame(0, 0);
    queue_frame(1, 0);
    set_frame(13'd0, 13'd0);
    queue_frame(0, 0);
    // bits above the 11-bit width field are dropped
    set_frame(13'h1803, 13'd2);
    queue_frame(1, 0);
    set_frame(13'd1, 13'd7);
    queue_frame(0, 0);
    set_frame(13'd2, 13'd2);
    queue_frame(1, 0);
    queue_frame(0, 1);
    set_frame(13'd3, 13'd1);
    queue_frame(1, 0);

    // random small frames, now and then cut short by a register write
    while (n_pixels_in < 900) begin
      set_frame(13'($urandom_range(8, 1)), 13'($urandom_range(6, 1)));
      repeat ($urandom_range(3, 1))
        queue_frame(1'($urandom_range(1)), $urandom_range(7) == 0);
      wait_drained();
    end
    set_frame(13'd5, 13'd3);
    queue_frame(1, 0);
    wait_drained();

    $display("%0d pixel transfers in, %0d blurred pixels checked, %0d frame ends",
             n_pixels_in, n_blurred, n_frame_ends);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ box_blur_3x3_edge_normalized_unit.f @@
design/bbe_pkg.sv
design/bbe_front.sv
design/bbe_fifo.sv
design/bbe_back.sv
design/box_blur_3x3_edge_normalized_unit.sv
dv/testbench.sv
